// ===== rtl/scrpar_pkg.sv =====
// Shared types, opcode map and opcode constants for the script instruction parser.
package scrpar_pkg;

    // Bit n set when opcode n is a defined opcode.
    localparam logic [255:0] OP_VALID_MAP = {
        32'h0000_0000, 32'h0000_0000, 32'h03FF_FFFF, 32'hFC1F_9F84,
        32'h3FFF_FF9F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF
    };

    localparam logic [7:0] DIRECT_PUSH_MIN = 8'h01;
    localparam logic [7:0] DIRECT_PUSH_MAX = 8'h4b;
    localparam logic [7:0] PUSH_BY_1       = 8'h4c;
    localparam logic [7:0] PUSH_BY_2       = 8'h4d;
    localparam logic [7:0] PUSH_BY_4       = 8'h4e;

    typedef enum logic [1:0] {
        ROLE_OPCODE  = 2'd0,
        ROLE_LENGTH  = 2'd1,
        ROLE_DATA    = 2'd2,
        ROLE_IGNORED = 2'd3
    } role_t;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_BAD_OPCODE = 2'd1,
        ERR_TRUNCATED  = 2'd2
    } err_t;

    typedef struct packed {
        logic       valid;
        logic       direct;
        logic [2:0] prefix_len;
    } op_class_t;

    typedef struct packed {
        role_t       role;
        logic [7:0]  opcode;
        logic [7:0]  value;
        logic        done;
        logic [31:0] start;
        logic [31:0] plen;
        logic [32:0] size;
        err_t        err;
    } result_t;

endpackage

// ===== rtl/scrpar_opclass.sv =====
// Opcode classifier: validity lookup, direct push range and count prefix length.
module scrpar_opclass (
    input  logic [7:0]             opcode,
    output scrpar_pkg::op_class_t  cls
);

    always_comb begin
        cls.valid  = scrpar_pkg::OP_VALID_MAP[opcode];
        cls.direct = opcode inside {[scrpar_pkg::DIRECT_PUSH_MIN:scrpar_pkg::DIRECT_PUSH_MAX]};
        case (opcode)
            scrpar_pkg::PUSH_BY_1: cls.prefix_len = 3'd1;
            scrpar_pkg::PUSH_BY_2: cls.prefix_len = 3'd2;
            scrpar_pkg::PUSH_BY_4: cls.prefix_len = 3'd4;
            default:               cls.prefix_len = 3'd0;
        endcase
    end

endmodule

// ===== rtl/scrpar_fsm.sv =====
// Parser state machine: per-byte classification, counters and result formation.
module scrpar_fsm (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic [7:0]           script_byte,
    input  logic                 script_end,
    output scrpar_pkg::result_t  res
);

    typedef enum logic [1:0] {
        PH_OPCODE = 2'd0,
        PH_LENGTH = 2'd1,
        PH_DATA   = 2'd2
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [7:0]             held_opcode_reg, held_opcode_next;
    logic [2:0]             len_left_reg, len_left_next;
    logic [1:0]             len_shift_reg, len_shift_next;
    logic [31:0]            push_count_reg, push_count_next;
    logic [31:0]            data_left_reg, data_left_next;
    logic [31:0]            start_offset_reg, start_offset_next;
    logic [31:0]            byte_offset_reg;
    scrpar_pkg::err_t       error_code_reg, error_code_next;

    scrpar_pkg::op_class_t  in_cls;
    scrpar_pkg::op_class_t  held_cls;

    scrpar_opclass u_in_class (
        .opcode (script_byte),
        .cls    (in_cls)
    );

    scrpar_opclass u_held_class (
        .opcode (held_opcode_reg),
        .cls    (held_cls)
    );

    always_comb begin
        phase_next        = phase_reg;
        held_opcode_next  = held_opcode_reg;
        len_left_next     = len_left_reg;
        len_shift_next    = len_shift_reg;
        push_count_next   = push_count_reg;
        data_left_next    = data_left_reg;
        start_offset_next = start_offset_reg;
        error_code_next   = error_code_reg;

        res        = '0;
        res.role   = scrpar_pkg::ROLE_IGNORED;
        res.value  = script_byte;

        if (error_code_reg == scrpar_pkg::ERR_NONE) begin
            case (phase_reg)
                PH_OPCODE: begin
                    res.role          = scrpar_pkg::ROLE_OPCODE;
                    held_opcode_next  = script_byte;
                    start_offset_next = byte_offset_reg;
                    push_count_next   = '0;
                    if (!in_cls.valid) begin
                        error_code_next = scrpar_pkg::ERR_BAD_OPCODE;
                    end else if (in_cls.direct) begin
                        push_count_next = {24'd0, script_byte};
                        data_left_next  = {24'd0, script_byte};
                        phase_next      = PH_DATA;
                    end else if (in_cls.prefix_len != 3'd0) begin
                        len_left_next  = in_cls.prefix_len;
                        len_shift_next = 2'd0;
                        phase_next     = PH_LENGTH;
                    end else begin
                        res.done = 1'b1;
                        res.size = 33'd1;
                    end
                end
                PH_LENGTH: begin
                    res.role        = scrpar_pkg::ROLE_LENGTH;
                    // little-endian count, one byte lane per length byte
                    push_count_next = push_count_reg
                                    | ({24'd0, script_byte} << {len_shift_reg, 3'b000});
                    len_shift_next  = len_shift_reg + 2'd1;
                    len_left_next   = len_left_reg - 3'd1;
                    if (len_left_reg == 3'd1) begin
                        if (push_count_next == '0) begin
                            res.done   = 1'b1;
                            res.size   = 33'd1 + {30'd0, held_cls.prefix_len};
                            phase_next = PH_OPCODE;
                        end else begin
                            data_left_next = push_count_next;
                            phase_next     = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    res.role       = scrpar_pkg::ROLE_DATA;
                    data_left_next = data_left_reg - 32'd1;
                    if (data_left_reg == 32'd1) begin
                        res.done   = 1'b1;
                        res.size   = 33'd1 + {30'd0, held_cls.prefix_len}
                                   + {1'b0, push_count_reg};
                        phase_next = PH_OPCODE;
                    end
                end
                default: begin
                    phase_next = PH_OPCODE;
                end
            endcase
            res.opcode = held_opcode_next;
            res.start  = start_offset_next;
            res.plen   = push_count_next;
            // script stopped part way through an instruction
            if (script_end && error_code_next == scrpar_pkg::ERR_NONE
                && phase_next != PH_OPCODE) begin
                error_code_next = scrpar_pkg::ERR_TRUNCATED;
            end
        end
        res.err = error_code_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && script_end)) begin
            phase_reg        <= PH_OPCODE;
            held_opcode_reg  <= '0;
            len_left_reg     <= '0;
            len_shift_reg    <= '0;
            push_count_reg   <= '0;
            data_left_reg    <= '0;
            start_offset_reg <= '0;
            byte_offset_reg  <= '0;
            error_code_reg   <= scrpar_pkg::ERR_NONE;
        end else if (step) begin
            phase_reg        <= phase_next;
            held_opcode_reg  <= held_opcode_next;
            len_left_reg     <= len_left_next;
            len_shift_reg    <= len_shift_next;
            push_count_reg   <= push_count_next;
            data_left_reg    <= data_left_next;
            start_offset_reg <= start_offset_next;
            byte_offset_reg  <= byte_offset_reg + 32'd1;
            error_code_reg   <= error_code_next;
        end
    end

`ifndef SYNTHESIS
    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (error_code_reg != scrpar_pkg::ERR_NONE && !(step && script_end))
        |=> (error_code_reg == $past(error_code_reg)))
        else $error("sticky error changed before end of script");

    a_len_left: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_LENGTH) |-> (len_left_reg != 3'd0))
        else $error("length phase with no length bytes left");

    a_data_left: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DATA) |-> (data_left_reg != 32'd0))
        else $error("data phase with no data bytes left");

    a_done_size: assert property (@(posedge aclk) disable iff (!aresetn)
        res.done == (res.size != 33'd0))
        else $error("instruction size disagrees with done flag");
`endif

endmodule

// ===== rtl/script_instruction_parser.sv =====
// Top level of the script instruction parser: handshakes and result register.
//
// Usage:
//   Input channel (s_*): one script byte per request, s_script_end marks the
//   final byte of a script. Result channel (m_*): exactly one result per
//   input byte, in order, giving the byte's role (opcode, length, data or
//   ignored after an error), the opcode of its instruction, the
//   instruction's start offset, push length, encoded size on the completing
//   byte, and the error code.
//   Results are registered: a result appears in the cycle after its byte is taken.
//   Throughput: one byte per cycle while not stalled; the parser state advances by
//   one byte in a single pass through the classifier and counter logic.
//   Stall: s_ready drops only while a result sits in the output register
//   and m_ready is low; the state machine then holds.
//   Reset (aresetn low, synchronous) empties the output register and puts
//   the parser back to expecting an opcode at offset zero with no error.
//   The same return to the idle state happens after any byte marked as the
//   end of a script, so the next script starts clean.
module script_instruction_parser (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_script_byte,
    input  logic        s_script_end,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_byte_role,
    output logic [7:0]  m_current_opcode,
    output logic [7:0]  m_byte_value,
    output logic        m_instr_done,
    output logic [31:0] m_instr_start,
    output logic [31:0] m_push_length,
    output logic [32:0] m_instr_size,
    output logic [1:0]  m_error_code
);

    logic                 accept;
    logic                 m_valid_reg;
    scrpar_pkg::result_t  step_res;
    scrpar_pkg::result_t  result_reg;

    // output register frees up as its result is taken
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    scrpar_fsm u_fsm (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (accept),
        .script_byte (s_script_byte),
        .script_end  (s_script_end),
        .res         (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (accept) begin
            result_reg <= step_res;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_byte_role      = result_reg.role;
    assign m_current_opcode = result_reg.opcode;
    assign m_byte_value     = result_reg.value;
    assign m_instr_done     = result_reg.done;
    assign m_instr_start    = result_reg.start;
    assign m_push_length    = result_reg.plen;
    assign m_instr_size     = result_reg.size;
    assign m_error_code     = result_reg.err;

endmodule
